// ----- rtl/alc_pkg.sv -----
// ----------------------------------------------------------------------------
// alc_pkg: shared types and constants of the access lockout controller
// Item layouts, configuration register set, mode and event codes.
// ----------------------------------------------------------------------------
package alc_pkg;

  localparam int UID_W    = 32;
  localparam int MS_W     = 16;
  localparam int FAIL_W   = 4;
  localparam int REMAIN_W = 7;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // input item kinds
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_CARD   = 2'd1;
  localparam logic [1:0] KIND_ABSENT = 2'd2;
  localparam logic [1:0] KIND_PIN    = 2'd3;

  // reported mode codes
  localparam logic [1:0] MODE_CODE_IDLE     = 2'd0;
  localparam logic [1:0] MODE_CODE_UNLOCKED = 2'd1;
  localparam logic [1:0] MODE_CODE_DENIED   = 2'd2;
  localparam logic [1:0] MODE_CODE_LOCKOUT  = 2'd3;

  // event codes
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_CARD_OK  = 3'd1;
  localparam logic [2:0] EV_PIN_OK   = 3'd2;
  localparam logic [2:0] EV_CARD_BAD = 3'd3;
  localparam logic [2:0] EV_PIN_BAD  = 3'd4;
  localparam logic [2:0] EV_LOCKOUT  = 3'd5;
  localparam logic [2:0] EV_RELOCKED = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_UNLOCK_MS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DENIED_MS    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT_MS   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CARD_UID_A   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CARD_UID_B   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CARD_ENABLE  = 3'd6;

  // configuration reset values
  localparam logic [MS_W-1:0]   UNLOCK_MS_RST    = 16'd5000;
  localparam logic [MS_W-1:0]   DENIED_MS_RST    = 16'd2000;
  localparam logic [MS_W-1:0]   LOCKOUT_MS_RST   = 16'd30000;
  localparam logic [FAIL_W-1:0] MAX_FAILURES_RST = 4'd5;
  localparam logic [UID_W-1:0]  CARD_UID_A_RST   = 32'h1A18_0E01;
  localparam logic [UID_W-1:0]  CARD_UID_B_RST   = 32'h0000_0000;
  localparam logic [1:0]        CARD_ENABLE_RST  = 2'b01;

  localparam logic [FAIL_W-1:0] FAIL_SAT = 4'd15;
  localparam logic [MS_W-1:0]   MS_SAT   = 16'hFFFF;

  // floor(x / 1000) for 16-bit x as (x * RECIP_1000) >> RECIP_SHIFT
  localparam int               RECIP_SHIFT = 26;
  localparam logic [16:0]      RECIP_1000  = 17'd67109;

  typedef enum logic [3:0] {
    MODE_IDLE     = 4'b0001,
    MODE_UNLOCKED = 4'b0010,
    MODE_DENIED   = 4'b0100,
    MODE_LOCKOUT  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [UID_W-1:0] card_uid;
    logic             pin_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          mode;
    logic                door_open;
    logic [2:0]          event_res;
    logic                matched_entry;
    logic [FAIL_W-1:0]   failures;
    logic [REMAIN_W-1:0] remain_seconds;
  } out_item_t;

  typedef struct packed {
    logic [MS_W-1:0]   unlock_ms;
    logic [MS_W-1:0]   denied_ms;
    logic [MS_W-1:0]   lockout_ms;
    logic [FAIL_W-1:0] max_failures;
    logic [UID_W-1:0]  card_uid_a;
    logic [UID_W-1:0]  card_uid_b;
    logic [1:0]        card_enable;
  } cfg_t;

endpackage

// ----- rtl/alc_cfg.sv -----
// ----------------------------------------------------------------------------
// alc_cfg: configuration register file
// Holds timing limits, failure limit and the card table; write only.
// ----------------------------------------------------------------------------
module alc_cfg (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [alc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output alc_pkg::cfg_t                cfg
);
  import alc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unlock_ms    <= UNLOCK_MS_RST;
      cfg_r.denied_ms    <= DENIED_MS_RST;
      cfg_r.lockout_ms   <= LOCKOUT_MS_RST;
      cfg_r.max_failures <= MAX_FAILURES_RST;
      cfg_r.card_uid_a   <= CARD_UID_A_RST;
      cfg_r.card_uid_b   <= CARD_UID_B_RST;
      cfg_r.card_enable  <= CARD_ENABLE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_UNLOCK_MS:    cfg_r.unlock_ms    <= cfg_wdata[MS_W-1:0];
        CFG_DENIED_MS:    cfg_r.denied_ms    <= cfg_wdata[MS_W-1:0];
        CFG_LOCKOUT_MS:   cfg_r.lockout_ms   <= cfg_wdata[MS_W-1:0];
        CFG_MAX_FAILURES: cfg_r.max_failures <= cfg_wdata[FAIL_W-1:0];
        CFG_CARD_UID_A:   cfg_r.card_uid_a   <= cfg_wdata[UID_W-1:0];
        CFG_CARD_UID_B:   cfg_r.card_uid_b   <= cfg_wdata[UID_W-1:0];
        CFG_CARD_ENABLE:  cfg_r.card_enable  <= cfg_wdata[1:0];
        default: ;  // unknown index: drop the write
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- rtl/alc_core.sv -----
// ----------------------------------------------------------------------------
// alc_core: access mode state and per-item decision logic
// Updates mode, failure count, elapsed time and last-card memory once per
// item and forms the result item.
// ----------------------------------------------------------------------------
module alc_core #(
  parameter int CARD_ENTRIES = 2
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  alc_pkg::in_item_t   item,
  input  alc_pkg::cfg_t       cfg,
  output alc_pkg::out_item_t  result
);
  import alc_pkg::*;

  mode_t              mode_r, mode_nxt;
  logic [FAIL_W-1:0]  fail_r, fail_nxt;
  logic [MS_W-1:0]    elapsed_r, elapsed_nxt;
  logic [UID_W-1:0]   prev_uid_r, prev_uid_nxt;
  logic               prev_valid_r, prev_valid_nxt;

  logic [2:0]         ev;
  logic               entry;
  logic               hit_a, hit_b;
  logic [FAIL_W-1:0]  fail_inc;
  logic [MS_W-1:0]    elapsed_inc;
  logic [MS_W-1:0]    limit;
  logic [MS_W-1:0]    diff;
  logic [32:0]        prod;
  logic [REMAIN_W-1:0] remain;
  logic [1:0]         mode_code;

  assign hit_a = cfg.card_enable[0] && (item.card_uid == cfg.card_uid_a);
  assign hit_b = (CARD_ENTRIES > 1) && cfg.card_enable[1] &&
                 (item.card_uid == cfg.card_uid_b);

  assign fail_inc    = (fail_r != FAIL_SAT) ? fail_r + 4'd1 : fail_r;
  assign elapsed_inc = (elapsed_r != MS_SAT) ? elapsed_r + 16'd1 : elapsed_r;

  always_comb begin
    unique case (mode_r)
      MODE_UNLOCKED: limit = cfg.unlock_ms;
      MODE_DENIED:   limit = cfg.denied_ms;
      default:       limit = cfg.lockout_ms;
    endcase
  end

  always_comb begin
    mode_nxt       = mode_r;
    fail_nxt       = fail_r;
    elapsed_nxt    = elapsed_r;
    prev_uid_nxt   = prev_uid_r;
    prev_valid_nxt = prev_valid_r;
    ev             = EV_NONE;
    entry          = 1'b0;

    unique case (mode_r)
      MODE_IDLE: begin
        unique case (item.kind)
          KIND_CARD: begin
            if (!prev_valid_r || (item.card_uid != prev_uid_r)) begin
              prev_uid_nxt   = item.card_uid;
              prev_valid_nxt = 1'b1;
              elapsed_nxt    = '0;
              if (hit_a || hit_b) begin
                entry    = !hit_a;
                fail_nxt = '0;
                mode_nxt = MODE_UNLOCKED;
                ev       = EV_CARD_OK;
              end else begin
                fail_nxt = fail_inc;
                if (fail_inc >= cfg.max_failures) begin
                  mode_nxt = MODE_LOCKOUT;
                  ev       = EV_LOCKOUT;
                end else begin
                  mode_nxt = MODE_DENIED;
                  ev       = EV_CARD_BAD;
                end
              end
            end
          end
          KIND_ABSENT: prev_valid_nxt = 1'b0;
          KIND_PIN: begin
            elapsed_nxt = '0;
            if (item.pin_ok) begin
              fail_nxt = '0;
              mode_nxt = MODE_UNLOCKED;
              ev       = EV_PIN_OK;
            end else begin
              fail_nxt = fail_inc;
              if (fail_inc >= cfg.max_failures) begin
                mode_nxt = MODE_LOCKOUT;
                ev       = EV_LOCKOUT;
              end else begin
                mode_nxt = MODE_DENIED;
                ev       = EV_PIN_BAD;
              end
            end
          end
          default: ;  // tick in idle does nothing
        endcase
      end
      default: begin
        // timed modes only react to ticks
        if (item.kind == KIND_TICK) begin
          if (elapsed_inc >= limit) begin
            if (mode_r == MODE_UNLOCKED) ev = EV_RELOCKED;
            if (mode_r == MODE_LOCKOUT) fail_nxt = '0;
            mode_nxt       = MODE_IDLE;
            elapsed_nxt    = '0;
            prev_valid_nxt = 1'b0;
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
      end
    endcase
  end

  // remaining lockout seconds: floor(diff / 1000) + 1
  assign diff = cfg.lockout_ms - elapsed_nxt;
  assign prod = {17'd0, diff} * {16'd0, RECIP_1000};

  always_comb begin
    if ((mode_nxt == MODE_LOCKOUT) && (elapsed_nxt < cfg.lockout_ms))
      remain = prod[RECIP_SHIFT +: REMAIN_W] + 7'd1;
    else
      remain = '0;
  end

  always_comb begin
    unique case (mode_nxt)
      MODE_UNLOCKED: mode_code = MODE_CODE_UNLOCKED;
      MODE_DENIED:   mode_code = MODE_CODE_DENIED;
      MODE_LOCKOUT:  mode_code = MODE_CODE_LOCKOUT;
      default:       mode_code = MODE_CODE_IDLE;
    endcase
  end

  assign result.mode           = mode_code;
  assign result.door_open      = (mode_nxt == MODE_UNLOCKED);
  assign result.event_res      = ev;
  assign result.matched_entry  = entry;
  assign result.failures       = fail_nxt;
  assign result.remain_seconds = remain;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      fail_r       <= '0;
      elapsed_r    <= '0;
      prev_uid_r   <= '0;
      prev_valid_r <= 1'b0;
    end else if (step) begin
      mode_r       <= mode_nxt;
      fail_r       <= fail_nxt;
      elapsed_r    <= elapsed_nxt;
      prev_uid_r   <= prev_uid_nxt;
      prev_valid_r <= prev_valid_nxt;
    end
  end

endmodule

// ----- rtl/access_lockout_controller_unit.sv -----
// ----------------------------------------------------------------------------
// access_lockout_controller_unit: door access controller top level
// Card / PIN / tick items drive idle, unlocked, denied and lockout modes.
// ----------------------------------------------------------------------------
//  port group | direction | handshake          | payload
//  in_*       | input     | in_valid/in_stall  | in_item_t (kind, uid, pin_ok)
//  out_*      | output    | out_valid/out_stall| out_item_t (mode .. remain)
//  cfg_*      | input     | cfg_we             | cfg_index, cfg_wdata
//
//  One item per cycle sustained while out_stall is low; out_valid rises once
//  the item has passed the input register and then the result register
//  after the mode logic, and the result then leaves when out_stall is low.
//  The mode state updates in the cycle the item leaves the input register.
//  Reset is synchronous: mode idle, counters and card memory cleared, config
//  registers at defaults. out_stall backs up into in_stall only when both
//  the result and input registers hold an item.
// ----------------------------------------------------------------------------
module access_lockout_controller_unit #(
  parameter int CARD_ENTRIES = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  alc_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output alc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [alc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import alc_pkg::*;

  cfg_t      cfg;
  in_item_t  in_item_r;
  logic      in_valid_r;
  out_item_t out_item_r;
  logic      out_valid_r;
  out_item_t result;
  logic      step;

  // advance when the result register is empty or being drained
  assign step     = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = in_valid_r && !step;

  alc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  alc_core #(
    .CARD_ENTRIES (CARD_ENTRIES)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (in_item_r),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) in_item_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) out_item_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule

// ----- bench/alc_result_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alc_result_checker: result predictor and scoreboard for the door controller
// Watches the item channels and the register port, keeps its own copy of the
// door state and settings, predicts one result per accepted item and compares
// each result field by field, oldest prediction first.
// ----------------------------------------------------------------------------
module alc_result_checker #(
  parameter int CARD_ENTRIES = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  alc_pkg::in_item_t              in_data,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  alc_pkg::out_item_t             out_data,
  input  logic                           cfg_we,
  input  logic [alc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatches,
  output int                             due_count,
  output int                             live_items
);
  import alc_pkg::*;

  cfg_t              door_cfg;
  logic [1:0]        door_mode;
  logic [FAIL_W-1:0] fail_run;
  logic [MS_W-1:0]   mode_ms;
  logic [UID_W-1:0]  reader_uid;
  logic              reader_uid_held;
  bit                acted;
  out_item_t         door_results_due[$];

  function automatic logic [2:0] grant_access(logic [2:0] ev);
    fail_run  = '0;
    door_mode = MODE_CODE_UNLOCKED;
    mode_ms   = '0;
    return ev;
  endfunction

  function automatic logic [2:0] count_failure(logic [2:0] ev);
    if (fail_run != FAIL_SAT) begin
      fail_run = fail_run + 4'd1;
    end
    mode_ms = '0;
    if (fail_run >= door_cfg.max_failures) begin
      door_mode = MODE_CODE_LOCKOUT;
      return EV_LOCKOUT;
    end
    door_mode = MODE_CODE_DENIED;
    return ev;
  endfunction

  function automatic out_item_t predict_door_step(in_item_t it);
    out_item_t       r;
    logic [UID_W-1:0] roster [2];
    logic [2:0]      ev;
    logic [MS_W-1:0] limit_ms;
    logic            entry;
    bit              hit;
    int              left_ms;
    roster[0] = door_cfg.card_uid_a;
    roster[1] = door_cfg.card_uid_b;
    ev    = EV_NONE;
    entry = 1'b0;
    hit   = 1'b0;
    acted = 1'b0;
    if (door_mode == MODE_CODE_IDLE) begin
      case (it.kind)
        KIND_CARD: begin
          // same card still on the reader: drop it
          if (!reader_uid_held || it.card_uid != reader_uid) begin
            acted           = 1'b1;
            reader_uid      = it.card_uid;
            reader_uid_held = 1'b1;
            for (int i = 0; i < CARD_ENTRIES && i < 2; i++) begin
              if (!hit && door_cfg.card_enable[i] && roster[i] == it.card_uid) begin
                hit   = 1'b1;
                entry = i[0];
              end
            end
            ev = hit ? grant_access(EV_CARD_OK) : count_failure(EV_CARD_BAD);
          end
        end
        KIND_ABSENT: begin
          acted           = 1'b1;
          reader_uid_held = 1'b0;
        end
        KIND_PIN: begin
          acted = 1'b1;
          ev = it.pin_ok ? grant_access(EV_PIN_OK) : count_failure(EV_PIN_BAD);
        end
        default: ;
      endcase
    end else if (it.kind == KIND_TICK) begin
      acted = 1'b1;
      if (mode_ms != MS_SAT) begin
        mode_ms = mode_ms + 16'd1;
      end
      case (door_mode)
        MODE_CODE_UNLOCKED: limit_ms = door_cfg.unlock_ms;
        MODE_CODE_DENIED:   limit_ms = door_cfg.denied_ms;
        default:            limit_ms = door_cfg.lockout_ms;
      endcase
      if (mode_ms >= limit_ms) begin
        if (door_mode == MODE_CODE_UNLOCKED) begin
          ev = EV_RELOCKED;
        end
        if (door_mode == MODE_CODE_LOCKOUT) begin
          fail_run = '0;
        end
        door_mode       = MODE_CODE_IDLE;
        mode_ms         = '0;
        reader_uid_held = 1'b0;
      end
    end
    r.mode           = door_mode;
    r.door_open      = (door_mode == MODE_CODE_UNLOCKED);
    r.event_res      = ev;
    r.matched_entry  = entry;
    r.failures       = fail_run;
    r.remain_seconds = '0;
    // a lockout shortened below the time already spent shows zero seconds
    if (door_mode == MODE_CODE_LOCKOUT && mode_ms < door_cfg.lockout_ms) begin
      left_ms = int'(door_cfg.lockout_ms) - int'(mode_ms);
      r.remain_seconds = REMAIN_W'(left_ms / 1000 + 1);
    end
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      door_cfg.unlock_ms    = UNLOCK_MS_RST;
      door_cfg.denied_ms    = DENIED_MS_RST;
      door_cfg.lockout_ms   = LOCKOUT_MS_RST;
      door_cfg.max_failures = MAX_FAILURES_RST;
      door_cfg.card_uid_a   = CARD_UID_A_RST;
      door_cfg.card_uid_b   = CARD_UID_B_RST;
      door_cfg.card_enable  = CARD_ENABLE_RST;
      door_mode       = MODE_CODE_IDLE;
      fail_run        = '0;
      mode_ms         = '0;
      reader_uid      = '0;
      reader_uid_held = 1'b0;
      door_results_due.delete();
      mismatches = 0;
      live_items = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_UNLOCK_MS:    door_cfg.unlock_ms    = cfg_wdata[MS_W-1:0];
          CFG_DENIED_MS:    door_cfg.denied_ms    = cfg_wdata[MS_W-1:0];
          CFG_LOCKOUT_MS:   door_cfg.lockout_ms   = cfg_wdata[MS_W-1:0];
          CFG_MAX_FAILURES: door_cfg.max_failures = cfg_wdata[FAIL_W-1:0];
          CFG_CARD_UID_A:   door_cfg.card_uid_a   = cfg_wdata[UID_W-1:0];
          CFG_CARD_UID_B:   door_cfg.card_uid_b   = cfg_wdata[UID_W-1:0];
          CFG_CARD_ENABLE:  door_cfg.card_enable  = cfg_wdata[1:0];
          default: ;
        endcase
      end
      // compare before pushing so a stray result never meets a fresh prediction
      if (out_valid && !out_stall) begin
        if (door_results_due.size() == 0) begin
          $error("result %h arrived with no item waiting for it", out_data);
          mismatches++;
        end else begin
          want = door_results_due.pop_front();
          check_field("mode", int'(want.mode), int'(out_data.mode));
          check_field("door_open", int'(want.door_open), int'(out_data.door_open));
          check_field("event_res", int'(want.event_res), int'(out_data.event_res));
          check_field("matched_entry", int'(want.matched_entry),
                      int'(out_data.matched_entry));
          check_field("failures", int'(want.failures), int'(out_data.failures));
          check_field("remain_seconds", int'(want.remain_seconds),
                      int'(out_data.remain_seconds));
        end
      end
      if (in_valid && !in_stall) begin
        door_results_due.push_back(predict_door_step(in_data));
        if (acted) begin
          live_items++;
        end
      end
    end
    due_count = door_results_due.size();
  end

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the access lockout controller
// Directed card, PIN and tick items through every mode and corner, then
// random phases of items under changing register settings, with random
// idling on both channels, a long output hold-off and drains between phases.
// ----------------------------------------------------------------------------
module tb;
  import alc_pkg::*;

  localparam int     HALF_PERIOD   = 10;
  localparam int     HOLD_CYCLES   = 60;
  localparam int     RANDOM_TARGET = 1600;
  localparam int     CALM_TAIL     = 200;
  localparam int     DRAIN_LIMIT   = 2000;
  localparam longint RUN_LIMIT_NS  = 40_000_000;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd7;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  in_item_t              in_data   = '0;
  logic                  in_stall;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  int               mismatches;
  int               due_count;
  int               live_items;
  int               gap_odds;
  int               stall_odds;
  bit               hold_req;
  int               items_sent;
  int               settings_seen;
  logic [UID_W-1:0] uid_a_now;
  logic [UID_W-1:0] uid_b_now;
  logic [UID_W-1:0] uid_last;

  access_lockout_controller_unit #(.CARD_ENTRIES(2)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  alc_result_checker #(.CARD_ENTRIES(2)) results (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .mismatches (mismatches),
    .due_count  (due_count),
    .live_items (live_items)
  );

  initial begin
    forever #HALF_PERIOD clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb: errors");
    $finish;
  end

  // receiver: random stall bursts, or one long hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (stall_odds != 0 && $urandom_range(0, 15) < stall_odds) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(logic [1:0] kind, logic [UID_W-1:0] uid, logic pin);
    if (gap_odds != 0 && $urandom_range(0, 15) < gap_odds) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind: kind, card_uid: uid, pin_ok: pin};
    if (kind == KIND_CARD) begin
      uid_last = uid;
    end
    items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid and wait until every result is out
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (due_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    if (idx == CFG_CARD_UID_A) begin
      uid_a_now = data;
    end
    if (idx == CFG_CARD_UID_B) begin
      uid_b_now = data;
    end
    @(posedge clk);
  endtask

  task automatic close_writes();
    cfg_we <= 1'b0;
    settings_seen++;
  endtask

  function automatic logic [MS_W-1:0] pick_ms(bit wide);
    if (wide) begin
      return ($urandom_range(0, 1) != 0) ? MS_SAT : MS_W'($urandom_range(1000, 65535));
    end
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return 16'd1;
      default: return MS_W'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic logic [UID_W-1:0] pick_table_uid();
    case ($urandom_range(0, 4))
      0:       return uid_b_now;
      1:       return '0;
      2:       return '1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int               base;
    int               phase;
    int               phase_len;
    int               roll;
    int               wait_cycles;
    bit               wide;
    logic [1:0]       kind;
    logic [UID_W-1:0] uid;
    logic             pin;
    gap_odds      = 2;
    stall_odds    = 2;
    hold_req      = 1'b0;
    items_sent    = 0;
    settings_seen = 0;
    uid_a_now     = CARD_UID_A_RST;
    uid_b_now     = CARD_UID_B_RST;
    uid_last      = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // default table card, then inputs ignored while open
    send_item(KIND_CARD, CARD_UID_A_RST, 1'b0);
    send_item(KIND_PIN, '0, 1'b0);
    send_item(KIND_ABSENT, '0, 1'b1);
    settle_block();
    write_reg(CFG_UNLOCK_MS, 32'd2);
    write_reg(CFG_DENIED_MS, 32'd1);
    write_reg(CFG_LOCKOUT_MS, 32'h0000_FFFF);
    write_reg(CFG_MAX_FAILURES, 32'd2);
    write_reg(CFG_CARD_UID_B, 32'hFFFF_FFFF);
    write_reg(CFG_CARD_ENABLE, 32'd3);
    write_reg(CFG_SPARE, 32'hFFFF_FFFF);
    close_writes();
    // relock, idle tick, second table entry, denied, then lockout at full length
    send_item(KIND_TICK, '0, 1'b0);
    send_item(KIND_TICK, '0, 1'b0);
    send_item(KIND_TICK, '0, 1'b0);
    send_item(KIND_CARD, 32'hFFFF_FFFF, 1'b1);
    send_item(KIND_TICK, '0, 1'b0);
    send_item(KIND_TICK, '0, 1'b0);
    send_item(KIND_CARD, 32'h0000_0000, 1'b0);
    send_item(KIND_TICK, '0, 1'b0);
    send_item(KIND_ABSENT, '0, 1'b0);
    send_item(KIND_PIN, '0, 1'b0);
    send_item(KIND_TICK, '0, 1'b0);
    send_item(KIND_CARD, CARD_UID_A_RST, 1'b0);
    // cut the lockout below the time already spent
    settle_block();
    write_reg(CFG_LOCKOUT_MS, 32'd0);
    close_writes();
    send_item(KIND_PIN, '0, 1'b1);
    send_item(KIND_TICK, '0, 1'b0);
    // both entries match: lowest wins; zero failure limit locks at once
    settle_block();
    write_reg(CFG_MAX_FAILURES, 32'd0);
    write_reg(CFG_CARD_UID_A, 32'hFFFF_FFFF);
    write_reg(CFG_UNLOCK_MS, 32'd0);
    close_writes();
    send_item(KIND_CARD, 32'hFFFF_FFFF, 1'b0);
    send_item(KIND_TICK, '0, 1'b0);
    send_item(KIND_PIN, '0, 1'b1);
    send_item(KIND_TICK, '0, 1'b0);
    send_item(KIND_PIN, '0, 1'b0);
    send_item(KIND_TICK, '0, 1'b0);

    base  = items_sent;
    phase = 0;
    while (items_sent - base < RANDOM_TARGET) begin
      settle_block();
      wide = (phase % 8 == 5);
      write_reg(CFG_UNLOCK_MS, {16'($urandom), pick_ms(wide)});
      write_reg(CFG_DENIED_MS, {16'($urandom), pick_ms(wide)});
      write_reg(CFG_LOCKOUT_MS, {16'($urandom), pick_ms(wide)});
      write_reg(CFG_MAX_FAILURES, {28'($urandom), 4'($urandom_range(0, 15))});
      write_reg(CFG_CARD_ENABLE, {30'($urandom), 2'($urandom_range(0, 3))});
      if ($urandom_range(0, 1) != 0) begin
        write_reg(CFG_CARD_UID_B, pick_table_uid());
      end
      if ($urandom_range(0, 1) != 0) begin
        write_reg(CFG_CARD_UID_A, pick_table_uid());
      end
      if ($urandom_range(0, 7) == 0) begin
        write_reg(CFG_SPARE, $urandom);
      end
      close_writes();
      if (items_sent - base >= RANDOM_TARGET - CALM_TAIL) begin
        gap_odds   = 0;
        stall_odds = 0;
      end else begin
        gap_odds   = $urandom_range(0, 4);
        stall_odds = $urandom_range(0, 4);
      end
      if (phase == 2) begin
        hold_req = 1'b1;
      end
      phase_len = wide ? 30 : $urandom_range(60, 160);
      repeat (phase_len) begin
        roll = $urandom_range(0, 99);
        uid  = $urandom;
        pin  = $urandom_range(0, 1);
        if (roll < 45) begin
          kind = KIND_TICK;
        end else if (roll < 75) begin
          kind = KIND_CARD;
          case ($urandom_range(0, 7))
            0, 1:    uid = uid_a_now;
            2:       uid = uid_b_now;
            3:       uid = uid_last;
            4:       uid = '0;
            5:       uid = '1;
            default: ;
          endcase
        end else if (roll < 85) begin
          kind = KIND_ABSENT;
        end else begin
          kind = KIND_PIN;
        end
        send_item(kind, uid, pin);
      end
      phase++;
    end

    in_valid <= 1'b0;
    @(posedge clk);
    wait_cycles = 0;
    while (due_count != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (due_count != 0) begin
      $error("%0d predicted results never came out", due_count);
    end
    $display("tb: %0d items sent under %0d register settings, %0d acted on the door state",
             items_sent, settings_seen, live_items);
    $display("tb: %0d random phases, one long output hold-off", phase);
    if (mismatches == 0 && due_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ----- access_lockout_controller_unit.f -----
rtl/alc_pkg.sv
rtl/alc_cfg.sv
rtl/alc_core.sv
rtl/access_lockout_controller_unit.sv
bench/alc_result_checker.sv
bench/tb.sv
